### hdl/bmap_pkg.sv
// shared types and constants of the banked rom mapper
`default_nettype none

package bmap_pkg;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_PRG   = 2'd2,
		MODE_CHR   = 2'd3
	} mode_t;

	// register decode key {address[15:13], address[0]} for writes at 0x8000 and above
	localparam logic [3:0] KEY_BANK_SELECT = 4'b1000;
	localparam logic [3:0] KEY_BANK_DATA   = 4'b1001;
	localparam logic [3:0] KEY_MIRROR      = 4'b1010;
	localparam logic [3:0] KEY_IRQ_LATCH   = 4'b1100;
	localparam logic [3:0] KEY_IRQ_RELOAD  = 4'b1101;
	localparam logic [3:0] KEY_IRQ_DISABLE = 4'b1110;
	localparam logic [3:0] KEY_IRQ_ENABLE  = 4'b1111;

	// bank_select low bits
	localparam logic [2:0] SEL_CHR_PAIR_LOW  = 3'd0;
	localparam logic [2:0] SEL_CHR_PAIR_HIGH = 3'd1;
	localparam logic [2:0] SEL_CHR_SINGLE0   = 3'd2;
	localparam logic [2:0] SEL_CHR_SINGLE1   = 3'd3;
	localparam logic [2:0] SEL_CHR_SINGLE2   = 3'd4;
	localparam logic [2:0] SEL_CHR_SINGLE3   = 3'd5;
	localparam logic [2:0] SEL_PRG_FIRST     = 3'd6;
	localparam logic [2:0] SEL_PRG_SECOND    = 3'd7;

	localparam logic [15:0] EXTRA_BITS_LOW  = 16'h4100;
	localparam logic [15:0] EXTRA_BITS_END  = 16'h6000;

	localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
	localparam logic [1:0] CFG_CHR_COUNT   = 2'd1;
	localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

	localparam logic [1:0] MIRROR_VERTICAL    = 2'd0;
	localparam logic [1:0] MIRROR_HORIZONTAL  = 2'd1;
	localparam logic [1:0] MIRROR_FOUR_SCREEN = 2'd2;

	// irq flag bits
	localparam int FLAG_ENABLE     = 0;
	localparam int FLAG_REQUEST    = 1;
	localparam int FLAG_PRESET     = 2;
	localparam int FLAG_PRESET_VBL = 3;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] address;
		logic [7:0]  data;
		logic        visible;
		logic        display;
	} item_t;

	typedef struct packed {
		logic [7:0]       bank_select;
		logic [7:0]       prg_first;
		logic [7:0]       prg_second;
		logic [7:0]       chr_pair_low;
		logic [7:0]       chr_pair_high;
		logic [3:0][7:0]  chr_single;
		logic             low_extra;
		logic             high_extra;
	} bank_regs_t;

	typedef struct packed {
		logic [8:0] prg_count;
		logic [9:0] chr_count;
		logic       four_screen;
	} cfg_t;

	typedef struct packed {
		logic irq_level;
		logic mirror_horizontal;
	} status_t;

endpackage

`default_nettype wire

### hdl/bmap_ctrl.sv
// mapper register file, configuration and scanline irq counter
`default_nettype none

module bmap_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [9:0]         cfg_data,
	input  wire logic               step,
	input  wire bmap_pkg::item_t    item,
	output bmap_pkg::bank_regs_t    regs,
	output bmap_pkg::cfg_t          cfg,
	output bmap_pkg::status_t       status_next
);

	bmap_pkg::bank_regs_t regs_q, regs_d;
	bmap_pkg::cfg_t       cfg_q;
	logic [7:0] count_q, count_d;
	logic [7:0] reload_q, reload_d;
	logic [3:0] flags_q, flags_d;
	logic       level_q, level_d;
	logic       mirror_q, mirror_d;

	logic [3:0] key;
	logic [7:0] count_a, count_b;

	assign key = {item.address[15:13], item.address[0]};

	always_comb begin
		regs_d   = regs_q;
		count_d  = count_q;
		reload_d = reload_q;
		flags_d  = flags_q;
		level_d  = level_q;
		mirror_d = mirror_q;
		count_a  = flags_q[bmap_pkg::FLAG_PRESET_VBL] ? reload_q : count_q;
		count_b  = (count_a != 8'd0) ? count_a - 8'd1 : count_a;
		if (flags_q[bmap_pkg::FLAG_PRESET]) begin
			count_b = reload_q;
		end
		case (item.mode)
			bmap_pkg::MODE_WRITE: begin
				if (item.address[15]) begin
					case (key)
						bmap_pkg::KEY_BANK_SELECT: begin
							regs_d.bank_select = item.data;
						end
						bmap_pkg::KEY_BANK_DATA: begin
							case (regs_q.bank_select[2:0])
								bmap_pkg::SEL_CHR_PAIR_LOW:  regs_d.chr_pair_low = {item.data[7:1], 1'b0};
								bmap_pkg::SEL_CHR_PAIR_HIGH: regs_d.chr_pair_high = {item.data[7:1], 1'b0};
								bmap_pkg::SEL_CHR_SINGLE0:   regs_d.chr_single[0] = item.data;
								bmap_pkg::SEL_CHR_SINGLE1:   regs_d.chr_single[1] = item.data;
								bmap_pkg::SEL_CHR_SINGLE2:   regs_d.chr_single[2] = item.data;
								bmap_pkg::SEL_CHR_SINGLE3:   regs_d.chr_single[3] = item.data;
								bmap_pkg::SEL_PRG_FIRST:     regs_d.prg_first = item.data;
								bmap_pkg::SEL_PRG_SECOND:    regs_d.prg_second = item.data;
								default:                     regs_d.prg_second = item.data;
							endcase
						end
						bmap_pkg::KEY_MIRROR: begin
							if (!cfg_q.four_screen) begin
								mirror_d = item.data[0];
							end
						end
						bmap_pkg::KEY_IRQ_LATCH: begin
							reload_d = item.data;
						end
						bmap_pkg::KEY_IRQ_RELOAD: begin
							count_d = count_q | 8'h80;
							if (item.visible) begin
								flags_d[bmap_pkg::FLAG_PRESET] = 1'b1;
							end else begin
								flags_d[bmap_pkg::FLAG_PRESET_VBL] = 1'b1;
								flags_d[bmap_pkg::FLAG_PRESET]     = 1'b0;
							end
						end
						bmap_pkg::KEY_IRQ_DISABLE: begin
							flags_d[bmap_pkg::FLAG_ENABLE]  = 1'b0;
							flags_d[bmap_pkg::FLAG_REQUEST] = 1'b0;
							level_d = 1'b0;
						end
						bmap_pkg::KEY_IRQ_ENABLE: begin
							flags_d[bmap_pkg::FLAG_ENABLE]  = 1'b1;
							flags_d[bmap_pkg::FLAG_REQUEST] = 1'b0;
						end
						default: begin
						end
					endcase
				end else if (item.address > bmap_pkg::EXTRA_BITS_LOW
						&& item.address < bmap_pkg::EXTRA_BITS_END) begin
					regs_d.low_extra  = item.data[0];
					regs_d.high_extra = item.data[4];
				end
			end
			bmap_pkg::MODE_TICK: begin
				if (item.visible && item.display) begin
					count_d = count_b;
					flags_d[bmap_pkg::FLAG_PRESET_VBL] = 1'b0;
					flags_d[bmap_pkg::FLAG_PRESET]     = 1'b0;
					if (count_b == 8'd0) begin
						if (flags_q[bmap_pkg::FLAG_ENABLE]) begin
							flags_d[bmap_pkg::FLAG_REQUEST] = 1'b1;
							level_d = 1'b1;
						end
						flags_d[bmap_pkg::FLAG_PRESET] = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bank_select   <= 8'd0;
			regs_q.prg_first     <= 8'd0;
			regs_q.prg_second    <= 8'd1;
			regs_q.chr_pair_low  <= 8'd0;
			regs_q.chr_pair_high <= 8'd2;
			regs_q.chr_single    <= {8'd7, 8'd6, 8'd5, 8'd4};
			regs_q.low_extra     <= 1'b0;
			regs_q.high_extra    <= 1'b0;
			count_q  <= 8'd0;
			reload_q <= 8'hFF;
			flags_q  <= 4'd0;
			level_q  <= 1'b0;
			mirror_q <= 1'b0;
			cfg_q.prg_count   <= 9'd32;
			cfg_q.chr_count   <= 10'd256;
			cfg_q.four_screen <= 1'b0;
		end else begin
			if (step) begin
				regs_q   <= regs_d;
				count_q  <= count_d;
				reload_q <= reload_d;
				flags_q  <= flags_d;
				level_q  <= level_d;
				mirror_q <= mirror_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					bmap_pkg::CFG_PRG_COUNT:   cfg_q.prg_count <= cfg_data[8:0];
					bmap_pkg::CFG_CHR_COUNT:   cfg_q.chr_count <= cfg_data;
					bmap_pkg::CFG_FOUR_SCREEN: cfg_q.four_screen <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	assign regs = regs_q;
	assign cfg  = cfg_q;
	assign status_next.irq_level         = level_d;
	assign status_next.mirror_horizontal = mirror_d;

endmodule

`default_nettype wire

### hdl/bmap_xlate.sv
// program and pattern address to bank translation
`default_nettype none

module bmap_xlate (
	input  wire bmap_pkg::item_t      item,
	input  wire bmap_pkg::bank_regs_t regs,
	input  wire bmap_pkg::cfg_t       cfg,
	output logic [8:0]                bank
);

	logic [8:0] prg_mask, prg_second_last, prg_bank;
	logic [9:0] chr_mask;
	logic [1:0] prg_slot;
	logic       half, pairs_here, extra;
	logic [1:0] sub;
	logic [7:0] num;
	logic [8:0] chr_bank;

	assign prg_mask        = cfg.prg_count - 9'd1;
	assign prg_second_last = cfg.prg_count - 9'd2;
	assign prg_slot        = item.address[14:13];
	assign chr_mask        = cfg.chr_count - 10'd1;
	assign half            = item.address[12];
	assign sub             = item.address[11:10];
	assign pairs_here      = (half == regs.bank_select[7]);
	assign extra           = half ? regs.high_extra : regs.low_extra;

	always_comb begin
		if (prg_slot == 2'd3) begin
			prg_bank = prg_mask;
		end else if (prg_slot == 2'd1) begin
			prg_bank = {1'b0, regs.prg_second};
		end else if ((prg_slot == 2'd0) == !regs.bank_select[6]) begin
			prg_bank = {1'b0, regs.prg_first};
		end else begin
			prg_bank = prg_second_last;
		end
	end

	always_comb begin
		if (pairs_here) begin
			num = sub[1] ? regs.chr_pair_high : regs.chr_pair_low;
			num[0] = sub[0];
		end else begin
			num = regs.chr_single[sub];
		end
		if (cfg.chr_count == 10'd0) begin
			chr_bank = {6'd0, num[2:0]};
		end else begin
			chr_bank = {extra, num} & chr_mask[8:0];
		end
	end

	always_comb begin
		case (item.mode)
			bmap_pkg::MODE_PRG: bank = prg_bank & prg_mask;
			bmap_pkg::MODE_CHR: bank = chr_bank;
			default:            bank = 9'd0;
		endcase
	end

endmodule

`default_nettype wire

### hdl/banked_rom_mapper_scanline_irq.sv
// a beat is registered in the input register, and its result then in the result register
// throughput: one beat per cycle while the output is not stalled; state updates as the item leaves the input register
// the result register holds a waiting result, so a beat is still taken while the input register is empty
// reset: asynchronous, clears both valid flags and loads the mapper and config reset values
`default_nettype none

module banked_rom_mapper_scanline_irq (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // address[15:0], data[23:16], scanline_visible[24], display_on[25]
	input  wire logic [1:0]  s_tuser,   // mode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // bank[8:0], irq_line[9], mirroring[11:10]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);

	bmap_pkg::item_t      item_s1;
	logic                 valid_s1;
	logic                 valid_s2;
	logic [15:0]          tdata_s2;
	logic                 advance;
	logic                 step;
	bmap_pkg::bank_regs_t regs;
	bmap_pkg::cfg_t       cfg;
	bmap_pkg::status_t    status_next;
	logic [8:0]           bank;
	logic [1:0]           mirroring;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode    <= bmap_pkg::mode_t'(s_tuser);
			item_s1.address <= s_tdata[15:0];
			item_s1.data    <= s_tdata[23:16];
			item_s1.visible <= s_tdata[24];
			item_s1.display <= s_tdata[25];
		end
		if (step) begin
			tdata_s2 <= {4'd0, mirroring, status_next.irq_level, bank};
		end
	end

	bmap_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.step        (step),
		.item        (item_s1),
		.regs        (regs),
		.cfg         (cfg),
		.status_next (status_next)
	);

	bmap_xlate u_xlate (
		.item (item_s1),
		.regs (regs),
		.cfg  (cfg),
		.bank (bank)
	);

	assign mirroring = cfg.four_screen ? bmap_pkg::MIRROR_FOUR_SCREEN
		: (status_next.mirror_horizontal ? bmap_pkg::MIRROR_HORIZONTAL
		: bmap_pkg::MIRROR_VERTICAL);

	assign m_tvalid = valid_s2;
	assign m_tdata  = tdata_s2;

endmodule

`default_nettype wire

### hdl/bmap_checker.sv
// port checker for the banked rom mapper, bound to the top level
`default_nettype none

module bmap_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	logic [1:0] held_q;
	logic       in_beat, out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	// beats accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
		end else if (in_beat && !out_beat) begin
			held_q <= held_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			held_q <= held_q - 2'd1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_mirror_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[11:10] != 2'd3)
		else $error("mirroring code out of range");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> held_q != 2'd2 || out_beat)
		else $error("beat taken with both registers full");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> held_q != 2'd0)
		else $error("result without an accepted beat");

endmodule

bind banked_rom_mapper_scanline_irq bmap_checker u_bmap_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
